// ----- rtl/ibsp_pkg.sv -----
// Shared constants, codes and types of the icon record best-size picker.
`default_nettype none
package ibsp_pkg;

    localparam int unsigned MAX_LIST_WORDS = 1048576;
    // Word position counts up to and including the list limit.
    localparam int unsigned POS_W          = $clog2(MAX_LIST_WORDS) + 1;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned DIST_W         = 64;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned PADDR_W        = 4;
    localparam int unsigned PDATA_W        = 32;
    localparam int unsigned S_TDATA_W      = WORD_W;
    localparam int unsigned RESULT_BITS    = POS_W + 2 * WORD_W;
    localparam int unsigned M_TDATA_W      = ((RESULT_BITS + 7) / 8) * 8;
    localparam int unsigned M_TUSER_W      = 2;

    typedef enum logic [1:0] {
        REG_WANTED_WIDTH  = 2'd0,
        REG_WANTED_HEIGHT = 2'd1,
        REG_MAX_WIDTH     = 2'd2,
        REG_MAX_HEIGHT    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NONE     = 2'd1,
        STATUS_TOO_BIG  = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0] wanted_width;
        logic [CFG_W-1:0] wanted_height;
        logic [CFG_W-1:0] max_width;
        logic [CFG_W-1:0] max_height;
    } cfg_t;

    // One queue entry: a finished record offered as a candidate, a report
    // request at the end of the list, or both (the offer goes first).
    typedef struct packed {
        logic              offer;
        logic              report;
        logic              too_long;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
        logic [POS_W-1:0]  start;
    } cand_t;

endpackage
`default_nettype wire

// ----- rtl/ibsp_front.sv -----
// Front part: accepts list words, parses records and emits candidates and reports.
`default_nettype none
module ibsp_front import ibsp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // word[31:0]
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cand_t                     q_data
);

    typedef enum logic [3:0] {
        PH_WIDTH  = 4'b0001,
        PH_HEIGHT = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               too_long_reg, too_long_next;
    logic [WORD_W-1:0]  rw_reg, rw_next;
    logic [WORD_W-1:0]  rh_reg, rh_next;
    logic [POS_W-1:0]   rs_reg, rs_next;
    logic [DIST_W-1:0]  pl_reg, pl_next;
    logic [DIST_W-1:0]  area;
    logic               acc;
    logic               at_limit;
    logic               offer;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && !q_full;
    assign at_limit = (pos_reg >= POS_W'(MAX_LIST_WORDS));
    assign area     = DIST_W'(rw_reg) * DIST_W'(s_tdata);

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        rw_next       = rw_reg;
        rh_next       = rh_reg;
        rs_next       = rs_reg;
        pl_next       = pl_reg;
        offer         = 1'b0;
        q_data.width  = rw_reg;
        q_data.height = rh_reg;
        q_data.start  = rs_reg;
        if (phase_reg == PH_HEIGHT) begin
            q_data.height = s_tdata;
            q_data.start  = pos_reg + POS_W'(1);
        end
        if (acc) begin
            if (at_limit) begin
                too_long_next = 1'b1;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                unique case (phase_reg)
                    PH_WIDTH: begin
                        rw_next    = s_tdata;
                        phase_next = PH_HEIGHT;
                    end
                    PH_HEIGHT: begin
                        rh_next = s_tdata;
                        rs_next = pos_reg + POS_W'(1);
                        pl_next = area;
                        // A header of zero area is complete at once and ends parsing.
                        if (rw_reg == '0 || s_tdata == '0) begin
                            offer      = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_PIXELS;
                        end
                    end
                    PH_PIXELS: begin
                        pl_next = pl_reg - DIST_W'(1);
                        if (pl_reg == DIST_W'(1)) begin
                            offer      = 1'b1;
                            phase_next = PH_WIDTH;
                        end
                    end
                    PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tlast) begin
                pos_next      = '0;
                phase_next    = PH_WIDTH;
                too_long_next = 1'b0;
            end
        end
        q_data.offer    = offer;
        q_data.report   = s_tlast;
        q_data.too_long = too_long_reg || at_limit;
        q_push          = acc && (offer || s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WIDTH;
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        rw_reg <= rw_next;
        rh_reg <= rh_next;
        rs_reg <= rs_next;
        pl_reg <= pl_next;
    end

    // The end of a list always returns the parser to its starting point.
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && s_tlast |=> pos_reg == '0 && phase_reg == PH_WIDTH && !too_long_reg)
        else $error("parser not restarted after the last item");

endmodule
`default_nettype wire

// ----- rtl/ibsp_queue.sv -----
// Short queue of candidate and report entries between the front and back parts.
`default_nettype none
module ibsp_queue import ibsp_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire cand_t push_data,
    output logic       full,
    input  wire logic  pop,
    output cand_t      pop_data,
    output logic       empty
);

    cand_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ibsp_back.sv -----
// Back part: distance pipeline, best-record tracking and result formatting.
`default_nettype none
module ibsp_back import ibsp_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  q_empty,
    input  wire cand_t                 q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // pixel_start[20:0], chosen_width, chosen_height
    output logic [M_TUSER_W-1:0]       m_tuser   // status[1:0]
);

    logic              adv;
    logic [WORD_W-1:0] pref_width, pref_height;
    logic [WORD_W-1:0] dw, dh;
    logic [DIST_W:0]   dist_sum;
    logic [DIST_W-1:0] dist_sat;
    logic              take;
    logic              report;

    logic              a_valid_reg;
    cand_t             a_reg;
    logic [WORD_W-1:0] a_dw_reg, a_dh_reg;
    logic              b_valid_reg;
    cand_t             b_reg;
    logic [DIST_W-1:0] b_sx_reg, b_sy_reg;
    logic              c_valid_reg;
    cand_t             c_reg;
    logic [DIST_W-1:0] c_dist_reg;

    logic              have_best_reg, have_best_next;
    logic [WORD_W-1:0] best_w_reg, best_w_next;
    logic [WORD_W-1:0] best_h_reg, best_h_next;
    logic [POS_W-1:0]  best_start_reg, best_start_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;

    logic              e_valid_reg;
    logic              e_too_long_reg;
    logic              e_have_reg;
    logic [WORD_W-1:0] e_w_reg, e_h_reg;
    logic [POS_W-1:0]  e_start_reg;

    status_t           status;
    logic [M_TDATA_W-1:0] result;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // The whole back part moves together whenever the output register can take an item.
    assign adv      = !m_valid_reg || m_tready;
    assign q_pop    = adv && !q_empty;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    assign pref_width  = WORD_W'(cfg.wanted_width);
    assign pref_height = WORD_W'(cfg.wanted_height);
    assign dw = (q_data.width >= pref_width) ? q_data.width - pref_width
                                             : pref_width - q_data.width;
    assign dh = (q_data.height >= pref_height) ? q_data.height - pref_height
                                               : pref_height - q_data.height;

    assign dist_sum = {1'b0, b_sx_reg} + {1'b0, b_sy_reg};
    assign dist_sat = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];

    // A tie keeps the earlier record, so only a strictly smaller distance wins.
    assign take   = c_valid_reg && c_reg.offer &&
                    (!have_best_reg || c_dist_reg < best_dist_reg);
    assign report = c_valid_reg && c_reg.report;

    always_comb begin
        have_best_next  = have_best_reg;
        best_w_next     = best_w_reg;
        best_h_next     = best_h_reg;
        best_start_next = best_start_reg;
        best_dist_next  = best_dist_reg;
        if (take) begin
            have_best_next  = 1'b1;
            best_w_next     = c_reg.width;
            best_h_next     = c_reg.height;
            best_start_next = c_reg.start;
            best_dist_next  = c_dist_reg;
        end
    end

    always_comb begin
        result = '0;
        if (e_too_long_reg) begin
            status = STATUS_TOO_LONG;
        end else begin
            if (e_have_reg) begin
                result = M_TDATA_W'({e_h_reg, e_w_reg, e_start_reg});
            end
            if (!e_have_reg || e_w_reg == '0 || e_h_reg == '0) begin
                status = STATUS_NONE;
            end else if (e_w_reg > WORD_W'(cfg.max_width) ||
                         e_h_reg > WORD_W'(cfg.max_height)) begin
                status = STATUS_TOO_BIG;
            end else begin
                status = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            have_best_reg <= 1'b0;
            best_dist_reg <= '1;
        end else if (adv) begin
            a_valid_reg <= q_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            e_valid_reg <= report;
            m_valid_reg <= e_valid_reg;
            if (report) begin
                have_best_reg <= 1'b0;
                best_dist_reg <= '1;
            end else begin
                have_best_reg <= have_best_next;
                best_dist_reg <= best_dist_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg          <= q_data;
            a_dw_reg       <= dw;
            a_dh_reg       <= dh;
            b_reg          <= a_reg;
            b_sx_reg       <= DIST_W'(a_dw_reg) * DIST_W'(a_dw_reg);
            b_sy_reg       <= DIST_W'(a_dh_reg) * DIST_W'(a_dh_reg);
            c_reg          <= b_reg;
            c_dist_reg     <= dist_sat;
            best_w_reg     <= best_w_next;
            best_h_reg     <= best_h_next;
            best_start_reg <= best_start_next;
            e_too_long_reg <= c_reg.too_long;
            e_have_reg     <= have_best_next;
            e_w_reg        <= best_w_next;
            e_h_reg        <= best_h_next;
            e_start_reg    <= best_start_next;
            m_status_reg   <= status;
            m_data_reg     <= result;
        end
    end

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && report |=> !have_best_reg)
        else $error("best record not cleared after a report");

    a_empty_best_far: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_best_reg |-> best_dist_reg == '1)
        else $error("best distance not at its maximum while no record is held");

    a_too_long_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_TOO_LONG |-> m_tdata == '0)
        else $error("list-too-long result carries record fields");

endmodule
`default_nettype wire

// ----- rtl/icon_record_best_size_picker_top.sv -----
// A report goes through the queue, the pipeline, and the result and output registers.
// Throughput: one list word per cycle while the queue has room; the back part's
// distance pipeline and best-record stage take one queue entry per cycle while the
// output drains. A four-entry queue lets the parser keep accepting while a result
// waits. Reset (aresetn low, synchronous) clears the parser, the queue, the pipeline
// and the best record, and returns the registers to 56, 56, 100 and 100.
`default_nettype none
module icon_record_best_size_picker_top import ibsp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // word[31:0]
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // pixel_start[20:0], chosen_width[52:21],
                                                // chosen_height[84:53], zeros above
    output logic [M_TUSER_W-1:0]      m_tuser,  // status[1:0]
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    logic     q_push, q_pop, q_full, q_empty;
    cand_t    q_in, q_out;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wanted_width  <= CFG_W'(56);
            cfg_reg.wanted_height <= CFG_W'(56);
            cfg_reg.max_width     <= CFG_W'(100);
            cfg_reg.max_height    <= CFG_W'(100);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_WANTED_WIDTH:  cfg_reg.wanted_width  <= pwdata[CFG_W-1:0];
                REG_WANTED_HEIGHT: cfg_reg.wanted_height <= pwdata[CFG_W-1:0];
                REG_MAX_WIDTH:     cfg_reg.max_width     <= pwdata[CFG_W-1:0];
                REG_MAX_HEIGHT:    cfg_reg.max_height    <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WANTED_WIDTH:  prdata = PDATA_W'(cfg_reg.wanted_width);
            REG_WANTED_HEIGHT: prdata = PDATA_W'(cfg_reg.wanted_height);
            REG_MAX_WIDTH:     prdata = PDATA_W'(cfg_reg.max_width);
            REG_MAX_HEIGHT:    prdata = PDATA_W'(cfg_reg.max_height);
            default:           prdata = '0;
        endcase
    end

    ibsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ibsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ibsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
